[rtl/lrc_pkg.sv]
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants for the lidar return converter
// Widths, fixed-point constants, series divisors and pipeline payload types.
// ----------------------------------------------------------------------------
package lrc_pkg;

   // fraction bits of the trig magnitudes
   localparam int TRIG_FRAC_BITS = 16;
   localparam int TRIG_W         = TRIG_FRAC_BITS + 1;

   localparam int DIST_W  = 17;           // range in mm, 2 * count
   localparam int AZ_W    = 16;           // raw azimuth code
   localparam int QR_W    = 14;           // azimuth within a quadrant
   localparam int ANG_W   = 13;           // folded angle, 0..4500
   localparam int T_W     = 32;           // angle in radians, Q32
   localparam int P_W     = 33;           // series partial value, Q32 up to one
   localparam int H_W     = DIST_W + 8;   // horizontal range, 8 fraction bits
   localparam int MAG_W   = DIST_W;       // output magnitude before offset
   localparam int OFF_W   = 18;
   localparam int POS_W   = 19;
   localparam int LANES   = 4;
   localparam int CELLS   = 5;
   localparam int STEP_W  = 3;
   localparam int DIV_W   = 7;
   localparam int PIPE_DEPTH = 3 + 3 * CELLS + 4;
   localparam int FLIGHT_W   = 5;

   localparam logic [P_W-1:0]  Q32_ONE    = 33'h1_0000_0000;
   localparam logic [19:0]     DEG_TO_RAD = 20'd749613;
   localparam logic [AZ_W-1:0] AZ_FULL    = 16'd36000;
   localparam logic [AZ_W-1:0] AZ_Q1      = 16'd9000;
   localparam logic [AZ_W-1:0] AZ_Q2      = 16'd18000;
   localparam logic [AZ_W-1:0] AZ_Q3      = 16'd27000;
   localparam logic [QR_W-1:0] QUARTER    = 14'd9000;
   localparam logic [QR_W-1:0] OCTANT     = 14'd4500;

   localparam logic [POS_W:0] POS_MAX = 20'sd262143;
   localparam logic [POS_W:0] POS_MIN = -20'sd262144;

   // lanes of the series chain
   localparam int LANE_EL_SIN = 0;
   localparam int LANE_EL_COS = 1;
   localparam int LANE_AZ_SIN = 2;
   localparam int LANE_AZ_COS = 3;

   // Horner divisors per step; zero leaves the lane untouched
   localparam logic [DIV_W-1:0] SIN_DIV [CELLS] = '{7'd0, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [DIV_W-1:0] COS_DIV [CELLS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};

   // floor(2^32 / d): quotient estimate is exact or one low
   localparam logic [31:0] SIN_RCP [CELLS] = '{
      32'd0,
      32'(64'h1_0000_0000 / 72),
      32'(64'h1_0000_0000 / 42),
      32'(64'h1_0000_0000 / 20),
      32'(64'h1_0000_0000 / 6)
   };
   localparam logic [31:0] COS_RCP [CELLS] = '{
      32'(64'h1_0000_0000 / 90),
      32'(64'h1_0000_0000 / 56),
      32'(64'h1_0000_0000 / 30),
      32'(64'h1_0000_0000 / 12),
      32'(64'h1_0000_0000 / 2)
   };

   // vertical angle magnitude per channel, hundredths of a degree
   localparam logic [ANG_W-1:0] ELEV_HUND [16] = '{
      13'd1500, 13'd100, 13'd1300, 13'd300, 13'd1100, 13'd500, 13'd900, 13'd700,
      13'd700, 13'd900, 13'd500, 13'd1100, 13'd300, 13'd1300, 13'd100, 13'd1500
   };

   typedef enum logic [1:0] {
      CSR_OFFSET_X = 2'd0,
      CSR_OFFSET_Y = 2'd1,
      CSR_OFFSET_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIST_W-1:0] range_mm;
      logic [1:0]        quad;
      logic              swap;
      logic              el_neg;
      logic [T_W-1:0]    t_el;
      logic [T_W-1:0]    t_az;
   } side_type;

   typedef struct packed {
      side_type                  side;
      logic [T_W-1:0]            x2_el;
      logic [T_W-1:0]            x2_az;
      logic [LANES-1:0][P_W-1:0] p;
   } work_type;

endpackage

[rtl/lrc_front.sv]
// ----------------------------------------------------------------------------
// lrc_front: request decode and angle preparation
// Unpacks the request, wraps and folds the azimuth, looks up the elevation,
// converts both angles to radians and squares them.
// ----------------------------------------------------------------------------
module lrc_front import lrc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [7:0]     distance_low,
   input  logic [7:0]     distance_high,
   input  logic [7:0]     azimuth_low,
   input  logic [7:0]     azimuth_high,
   input  logic [3:0]     channel,
   output logic           out_valid,
   input  logic           out_ready,
   output work_type       out_work
);

   logic              s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic              s0_ready, s1_ready, s2_ready;
   side_type          s0_side_ff, s0_side_in;
   logic [ANG_W-1:0]  s0_r_az_ff, s0_r_az_in;
   logic [ANG_W-1:0]  s0_r_el_ff;
   side_type          s1_side_ff, s1_side_in;
   work_type          s2_work_ff, s2_work_in;

   logic [AZ_W-1:0]   az_code, az_wrap;
   logic [QR_W-1:0]   az_rem;
   logic [2*T_W-1:0]  sq_el, sq_az;

   // stall chain
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s0_ready = !s0_valid_ff || s1_ready;
   assign in_ready = s0_ready;

   // decode, wrap and fold the azimuth into the first octant
   always_comb begin
      az_code = {azimuth_high, azimuth_low};
      az_wrap = (az_code >= AZ_FULL) ? az_code - AZ_FULL : az_code;
      s0_side_in = '0;
      s0_side_in.range_mm = {distance_high, distance_low, 1'b0};
      s0_side_in.el_neg = ~channel[0];
      if (az_wrap >= AZ_Q3) begin
         s0_side_in.quad = 2'd3;
         az_rem = QR_W'(az_wrap - AZ_Q3);
      end else if (az_wrap >= AZ_Q2) begin
         s0_side_in.quad = 2'd2;
         az_rem = QR_W'(az_wrap - AZ_Q2);
      end else if (az_wrap >= AZ_Q1) begin
         s0_side_in.quad = 2'd1;
         az_rem = QR_W'(az_wrap - AZ_Q1);
      end else begin
         s0_side_in.quad = 2'd0;
         az_rem = QR_W'(az_wrap);
      end
      s0_side_in.swap = (az_rem > OCTANT);
      s0_r_az_in = s0_side_in.swap ? ANG_W'(QUARTER - az_rem) : ANG_W'(az_rem);
   end

   // radians in Q32
   always_comb begin
      s1_side_in = s0_side_ff;
      s1_side_in.t_el = T_W'(s0_r_el_ff * DEG_TO_RAD);
      s1_side_in.t_az = T_W'(s0_r_az_ff * DEG_TO_RAD);
   end

   // squares, series start at one
   always_comb begin
      sq_el = s1_side_ff.t_el * s1_side_ff.t_el;
      sq_az = s1_side_ff.t_az * s1_side_ff.t_az;
      s2_work_in.side  = s1_side_ff;
      s2_work_in.x2_el = sq_el[2*T_W-1:T_W];
      s2_work_in.x2_az = sq_az[2*T_W-1:T_W];
      for (int l = 0; l < LANES; l++) begin
         s2_work_in.p[l] = Q32_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s0_ready) s0_valid_ff <= in_valid;
         if (s1_ready) s1_valid_ff <= s0_valid_ff;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_side_ff <= s0_side_in;
         s0_r_az_ff <= s0_r_az_in;
         s0_r_el_ff <= ELEV_HUND[channel];
      end
      if (s1_ready) s1_side_ff <= s1_side_in;
      if (s2_ready) s2_work_ff <= s2_work_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_work  = s2_work_ff;

endmodule

[rtl/lrc_cell.sv]
// ----------------------------------------------------------------------------
// lrc_cell: one Horner step of the sine and cosine series
// Per lane with nonzero d computes p' = 1 - ((x2 * p) >> 32) / d over three stages:
// product, reciprocal estimate, correction and subtract.
// ----------------------------------------------------------------------------
module lrc_cell import lrc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [STEP_W-1:0] step,
   input  logic              in_valid,
   output logic              in_ready,
   input  work_type          in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output work_type          out_work
);

   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic a_ready, b_ready, c_ready;
   work_type a_work_ff, b_work_ff, c_work_ff, c_work_in;
   logic [LANES-1:0][T_W-1:0] a_v_ff, a_v_in;
   logic [LANES-1:0][T_W-1:0] b_v_ff;
   logic [LANES-1:0][T_W-1:0] b_q_ff, b_q_in;

   logic [LANES-1:0][DIV_W-1:0] lane_div;
   logic [LANES-1:0][31:0]      lane_rcp;
   logic [T_W+P_W-1:0]          prod;
   logic [2*T_W-1:0]            qprod;
   logic [T_W+DIV_W-1:0]        rem;
   logic [T_W-1:0]              quo;
   logic [T_W-1:0]              x2_lane;

   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // divisor and reciprocal of this step; even lanes sine, odd lanes cosine
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_div[l] = l[0] ? COS_DIV[step] : SIN_DIV[step];
         lane_rcp[l] = l[0] ? COS_RCP[step] : SIN_RCP[step];
      end
   end

   // stage A: x2 * p, Q32
   always_comb begin
      prod    = '0;
      x2_lane = '0;
      for (int l = 0; l < LANES; l++) begin
         x2_lane   = (l < 2) ? in_work.x2_el : in_work.x2_az;
         prod      = x2_lane * in_work.p[l];
         a_v_in[l] = prod[2*T_W-1:T_W];
      end
   end

   // stage B: quotient estimate by reciprocal
   always_comb begin
      qprod = '0;
      for (int l = 0; l < LANES; l++) begin
         qprod     = a_v_ff[l] * lane_rcp[l];
         b_q_in[l] = qprod[2*T_W-1:T_W];
      end
   end

   // stage C: fix the estimate and close the step
   always_comb begin
      c_work_in = b_work_ff;
      rem = '0;
      quo = '0;
      for (int l = 0; l < LANES; l++) begin
         rem = {{DIV_W{1'b0}}, b_v_ff[l]} - b_q_ff[l] * lane_div[l];
         quo = (rem >= {{T_W{1'b0}}, lane_div[l]}) ? b_q_ff[l] + 1'b1 : b_q_ff[l];
         if (lane_div[l] != '0) begin
            c_work_in.p[l] = Q32_ONE - {1'b0, quo};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_work_ff <= in_work;
         a_v_ff    <= a_v_in;
      end
      if (b_ready) begin
         b_work_ff <= a_work_ff;
         b_v_ff    <= a_v_ff;
         b_q_ff    <= b_q_in;
      end
      if (c_ready) c_work_ff <= c_work_in;
   end

   assign out_valid = c_valid_ff;
   assign out_work  = c_work_ff;

endmodule

[rtl/lrc_back.sv]
// ----------------------------------------------------------------------------
// lrc_back: trig completion, scaling and offsets
// Finishes sine and cosine, applies the quadrant, scales the range into
// x, y and z, adds the mount offsets and holds the response register.
// ----------------------------------------------------------------------------
module lrc_back import lrc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  work_type                in_work,
   input  logic signed [OFF_W-1:0] offset_x,
   input  logic signed [OFF_W-1:0] offset_y,
   input  logic signed [OFF_W-1:0] offset_z,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [POS_W-1:0] pos_x,
   output logic signed [POS_W-1:0] pos_y,
   output logic signed [POS_W-1:0] pos_z
);

   localparam logic [T_W+1:0]              RND_TRIG = (T_W+2)'(1) << (31 - TRIG_FRAC_BITS);
   localparam logic [DIST_W+TRIG_W:0]      RND_H    = (DIST_W+TRIG_W+1)'(1) << (TRIG_FRAC_BITS - 9);
   localparam logic [DIST_W+TRIG_W:0]      RND_Z    = (DIST_W+TRIG_W+1)'(1) << (TRIG_FRAC_BITS - 1);
   localparam logic [H_W+TRIG_W:0]         RND_XY   = (H_W+TRIG_W+1)'(1) << (TRIG_FRAC_BITS + 7);

   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s0_ready, s1_ready, s2_ready, s3_ready;

   // stage 0 registers
   side_type          s0_side_ff;
   logic [TRIG_W-1:0] s0_se_ff, s0_ce_ff, s0_sa_ff, s0_ca_ff;
   logic [TRIG_W-1:0] s0_se_in, s0_ce_in, s0_sa_in, s0_ca_in;
   // stage 1 registers
   logic [H_W-1:0]    s1_h_ff, s1_h_in;
   logic [MAG_W-1:0]  s1_z_ff, s1_z_in;
   logic [TRIG_W-1:0] s1_sa_ff, s1_ca_ff, s1_sa_in, s1_ca_in;
   logic              s1_san_ff, s1_can_ff, s1_san_in, s1_can_in, s1_zn_ff;
   // stage 2 registers
   logic [MAG_W-1:0]  s2_x_ff, s2_y_ff, s2_z_ff, s2_x_in, s2_y_in;
   logic              s2_xn_ff, s2_yn_ff, s2_zn_ff;
   // response register
   logic signed [POS_W-1:0] s3_x_ff, s3_y_ff, s3_z_ff;

   logic [T_W+P_W-1:0]       sp_el, sp_az;
   logic [T_W+1:0]           rs_el, rs_az, rc_el, rc_az;
   logic [TRIG_W-1:0]        sa0, ca0;
   logic [DIST_W+TRIG_W:0]   hp, zp;
   logic [H_W+TRIG_W:0]      xp, yp;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s0_ready = !s0_valid_ff || s1_ready;
   assign in_ready = s0_ready;

   // stage 0: sine = t * p, both values rounded half up to trig fraction bits
   always_comb begin
      sp_el = in_work.side.t_el * in_work.p[LANE_EL_SIN];
      sp_az = in_work.side.t_az * in_work.p[LANE_AZ_SIN];
      rs_el = {2'b00, sp_el[2*T_W-1:T_W]} + RND_TRIG;
      rs_az = {2'b00, sp_az[2*T_W-1:T_W]} + RND_TRIG;
      rc_el = {1'b0, in_work.p[LANE_EL_COS]} + RND_TRIG;
      rc_az = {1'b0, in_work.p[LANE_AZ_COS]} + RND_TRIG;
      s0_se_in = rs_el[T_W:T_W-TRIG_FRAC_BITS];
      s0_sa_in = rs_az[T_W:T_W-TRIG_FRAC_BITS];
      s0_ce_in = rc_el[T_W:T_W-TRIG_FRAC_BITS];
      s0_ca_in = rc_az[T_W:T_W-TRIG_FRAC_BITS];
   end

   // stage 1: octant swap, quadrant signs, horizontal range and z
   always_comb begin
      sa0 = s0_side_ff.swap ? s0_ca_ff : s0_sa_ff;
      ca0 = s0_side_ff.swap ? s0_sa_ff : s0_ca_ff;
      case (s0_side_ff.quad)
         2'd0: begin
            s1_sa_in = sa0; s1_san_in = 1'b0; s1_ca_in = ca0; s1_can_in = 1'b0;
         end
         2'd1: begin
            s1_sa_in = ca0; s1_san_in = 1'b0; s1_ca_in = sa0; s1_can_in = 1'b1;
         end
         2'd2: begin
            s1_sa_in = sa0; s1_san_in = 1'b1; s1_ca_in = ca0; s1_can_in = 1'b1;
         end
         default: begin
            s1_sa_in = ca0; s1_san_in = 1'b1; s1_ca_in = sa0; s1_can_in = 1'b0;
         end
      endcase
      hp = (DIST_W+TRIG_W+1)'(s0_side_ff.range_mm * s0_ce_ff) + RND_H;
      zp = (DIST_W+TRIG_W+1)'(s0_side_ff.range_mm * s0_se_ff) + RND_Z;
      s1_h_in = H_W'(hp >> (TRIG_FRAC_BITS - 8));
      s1_z_in = MAG_W'(zp >> TRIG_FRAC_BITS);
   end

   // stage 2: x and y magnitudes
   always_comb begin
      xp = (H_W+TRIG_W+1)'(s1_h_ff * s1_sa_ff) + RND_XY;
      yp = (H_W+TRIG_W+1)'(s1_h_ff * s1_ca_ff) + RND_XY;
      s2_x_in = MAG_W'(xp >> (TRIG_FRAC_BITS + 8));
      s2_y_in = MAG_W'(yp >> (TRIG_FRAC_BITS + 8));
   end

   // sign, offset and saturation
   function automatic logic signed [POS_W-1:0] finish(input logic [MAG_W-1:0] mag,
                                                      input logic neg,
                                                      input logic signed [OFF_W-1:0] off);
      logic signed [POS_W:0] sm;
      logic signed [POS_W:0] sum;
      sm  = neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
      sum = sm + (POS_W+1)'(off);
      if (sum > $signed(POS_MAX)) begin
         sum = $signed(POS_MAX);
      end else if (sum < $signed(POS_MIN)) begin
         sum = $signed(POS_MIN);
      end
      return sum[POS_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s0_ready) s0_valid_ff <= in_valid;
         if (s1_ready) s1_valid_ff <= s0_valid_ff;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_side_ff <= in_work.side;
         s0_se_ff   <= s0_se_in;
         s0_ce_ff   <= s0_ce_in;
         s0_sa_ff   <= s0_sa_in;
         s0_ca_ff   <= s0_ca_in;
      end
      if (s1_ready) begin
         s1_h_ff   <= s1_h_in;
         s1_z_ff   <= s1_z_in;
         s1_sa_ff  <= s1_sa_in;
         s1_ca_ff  <= s1_ca_in;
         s1_san_ff <= s1_san_in;
         s1_can_ff <= s1_can_in;
         s1_zn_ff  <= s0_side_ff.el_neg;
      end
      if (s2_ready) begin
         s2_x_ff  <= s2_x_in;
         s2_y_ff  <= s2_y_in;
         s2_z_ff  <= s1_z_ff;
         s2_xn_ff <= s1_san_ff;
         s2_yn_ff <= s1_can_ff;
         s2_zn_ff <= s1_zn_ff;
      end
      if (s3_ready) begin
         s3_x_ff <= finish(s2_x_ff, s2_xn_ff, offset_x);
         s3_y_ff <= finish(s2_y_ff, s2_yn_ff, offset_y);
         s3_z_ff <= finish(s2_z_ff, s2_zn_ff, offset_z);
      end
   end

   assign out_valid = s3_valid_ff;
   assign pos_x     = s3_x_ff;
   assign pos_y     = s3_y_ff;
   assign pos_z     = s3_z_ff;

endmodule

[rtl/lidar_return_to_cartesian.sv]
// ----------------------------------------------------------------------------
// lidar_return_to_cartesian: 16-channel lidar return to Cartesian position
// Converts one laser return (range, azimuth, channel) into x, y, z in mm.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_* (valid/ready): range bytes in 2 mm units, azimuth
//   bytes in hundredths of a degree, laser channel 0..15. Each request gives
//   exactly one response on rsp_* with signed 19-bit x, y, z in millimetres,
//   mount offsets from the csr_* write port already added.
//   Throughput is one request per cycle while rsp_ready holds. From accept to
//   response valid a request passes 3 decode/angle stages, a chain of 5 series
//   cells of 3 stages each (one Horner step of sine and cosine per cell), and
//   4 stages of scaling and offset including the response register.
//   Every stage has its own valid bit and stalls only when its successor is
//   full, so a waiting response does not block requests while bubbles remain.
//   Reset (synchronous) empties the pipeline and clears the offsets to zero.
//   Offsets must be written only while no request is in flight (the block does not check).
// ----------------------------------------------------------------------------
module lidar_return_to_cartesian import lrc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_distance_low,
   input  logic [7:0]              req_distance_high,
   input  logic [7:0]              req_azimuth_low,
   input  logic [7:0]              req_azimuth_high,
   input  logic [3:0]              req_channel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [POS_W-1:0] rsp_pos_x_mm,
   output logic signed [POS_W-1:0] rsp_pos_y_mm,
   output logic signed [POS_W-1:0] rsp_pos_z_mm,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [OFF_W-1:0]        csr_data
);

   logic signed [OFF_W-1:0] offset_x_ff, offset_y_ff, offset_z_ff;

   logic     chain_valid [CELLS+1];
   logic     chain_ready [CELLS+1];
   work_type chain_work  [CELLS+1];

   // offset registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OFFSET_X: offset_x_ff <= $signed(csr_data);
            CSR_OFFSET_Y: offset_y_ff <= $signed(csr_data);
            CSR_OFFSET_Z: offset_z_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   lrc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .distance_low  (req_distance_low),
      .distance_high (req_distance_high),
      .azimuth_low   (req_azimuth_low),
      .azimuth_high  (req_azimuth_high),
      .channel       (req_channel),
      .out_valid     (chain_valid[0]),
      .out_ready     (chain_ready[0]),
      .out_work      (chain_work[0])
   );

   // series cells, one Horner step each
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      lrc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (STEP_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_work   (chain_work[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_work  (chain_work[i+1])
      );
   end

   lrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CELLS]),
      .in_ready  (chain_ready[CELLS]),
      .in_work   (chain_work[CELLS]),
      .offset_x  (offset_x_ff),
      .offset_y  (offset_y_ff),
      .offset_z  (offset_z_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .pos_x     (rsp_pos_x_mm),
      .pos_y     (rsp_pos_y_mm),
      .pos_z     (rsp_pos_z_mm)
   );

   // requests in flight, for checking only
   logic [FLIGHT_W-1:0] flight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_ff + FLIGHT_W'(req_valid && req_ready)
                                - FLIGHT_W'(rsp_valid && rsp_ready);
      end
   end

   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      flight_ff <= FLIGHT_W'(PIPE_DEPTH))
      else $error("more requests in flight than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (flight_ff == '0) |-> !rsp_valid)
      else $error("response without an outstanding request");

   a_ready_through: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("stall chain blocked with the sink ready");

   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_offset_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == CSR_OFFSET_Z)
      |=> offset_z_ff == $signed($past(csr_data)))
      else $error("offset z write lost");

endmodule

[test/lidar_return_to_cartesian_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_return_to_cartesian_checker: position predictor and response checker
// Watches the request, response and register write channels, works out the
// expected x, y, z of every accepted request in fixed point and compares
// each accepted response against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lidar_return_to_cartesian_checker import lrc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [7:0]              req_distance_low,
   input  logic [7:0]              req_distance_high,
   input  logic [7:0]              req_azimuth_low,
   input  logic [7:0]              req_azimuth_high,
   input  logic [3:0]              req_channel,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [POS_W-1:0] rsp_pos_x_mm,
   input  logic signed [POS_W-1:0] rsp_pos_y_mm,
   input  logic signed [POS_W-1:0] rsp_pos_z_mm,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [OFF_W-1:0]        csr_data,
   output int                      fail_count,
   output int                      positions_pending
);

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } position_type;

   // interleaved vertical angles in degrees, per channel
   localparam int ELEV_DEG [16] = '{
      -15, 1, -13, 3, -11, 5, -9, 7, -7, 9, -5, 11, -3, 13, -1, 15
   };
   localparam logic [63:0] ONE_Q32      = 64'h1_0000_0000;
   localparam logic [63:0] HUND_TO_RAD  = 64'd749613;
   localparam longint      LIMIT_HIGH   = 262143;
   localparam longint      LIMIT_LOW    = -262144;

   position_type            expected_positions [$];
   logic signed [OFF_W-1:0] mount_x, mount_y, mount_z;

   function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> 32;
   endfunction

   function automatic logic [63:0] to_frac(input logic [63:0] v);
      return (v + (64'd1 << (31 - TRIG_FRAC_BITS))) >> (32 - TRIG_FRAC_BITS);
   endfunction

   function automatic logic [63:0] round_down_by(input logic [63:0] v, input int sh);
      return (v + (64'd1 << (sh - 1))) >> sh;
   endfunction

   // sine and cosine magnitudes of 0..45 degrees, truncating Horner series
   task automatic octant_trig(input int unsigned r, output logic [63:0] s,
                              output logic [63:0] c);
      logic [63:0] t, sq, p;
      t  = 64'(r) * HUND_TO_RAD;
      sq = q32_mul(t, t);
      p  = ONE_Q32;
      p  = ONE_Q32 - q32_mul(sq, p) / 64'd72;
      p  = ONE_Q32 - q32_mul(sq, p) / 64'd42;
      p  = ONE_Q32 - q32_mul(sq, p) / 64'd20;
      p  = ONE_Q32 - q32_mul(sq, p) / 64'd6;
      s  = to_frac(q32_mul(t, p));
      p  = ONE_Q32;
      p  = ONE_Q32 - q32_mul(sq, p) / 64'd90;
      p  = ONE_Q32 - q32_mul(sq, p) / 64'd56;
      p  = ONE_Q32 - q32_mul(sq, p) / 64'd30;
      p  = ONE_Q32 - q32_mul(sq, p) / 64'd12;
      p  = ONE_Q32 - q32_mul(sq, p) / 64'd2;
      c  = to_frac(p);
   endtask

   function automatic logic signed [POS_W-1:0] add_mount(input logic [63:0] mag,
         input logic neg, input logic signed [OFF_W-1:0] mount);
      longint v;
      v = neg ? -longint'(mag) : longint'(mag);
      v = v + longint'(mount);
      if (v > LIMIT_HIGH) v = LIMIT_HIGH;
      if (v < LIMIT_LOW) v = LIMIT_LOW;
      return v[POS_W-1:0];
   endfunction

   task automatic predict_position(input logic [15:0] count, input logic [15:0] az_code,
                                   input logic [3:0] chan, output position_type pos);
      logic [63:0]  range_mm, se, ce, s0, c0, sa, ca, h;
      logic         sa_neg, ca_neg;
      int unsigned  az, quad, rem;
      int           el;
      range_mm = 64'(count) * 64'd2;
      az   = int'(az_code) % 36000;
      el   = ELEV_DEG[chan];
      octant_trig((el < 0 ? -el : el) * 100, se, ce);
      quad = az / 9000;
      rem  = az % 9000;
      if (rem <= 4500) octant_trig(rem, s0, c0);
      else octant_trig(9000 - rem, c0, s0);
      // quadrant folding: swap and sign
      case (quad)
         0: begin sa = s0; sa_neg = 1'b0; ca = c0; ca_neg = 1'b0; end
         1: begin sa = c0; sa_neg = 1'b0; ca = s0; ca_neg = 1'b1; end
         2: begin sa = s0; sa_neg = 1'b1; ca = c0; ca_neg = 1'b1; end
         default: begin sa = c0; sa_neg = 1'b1; ca = s0; ca_neg = 1'b0; end
      endcase
      h     = round_down_by(range_mm * ce, TRIG_FRAC_BITS - 8);
      pos.x = add_mount(round_down_by(h * sa, TRIG_FRAC_BITS + 8), sa_neg, mount_x);
      pos.y = add_mount(round_down_by(h * ca, TRIG_FRAC_BITS + 8), ca_neg, mount_y);
      pos.z = add_mount(round_down_by(range_mm * se, TRIG_FRAC_BITS), el < 0, mount_z);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign positions_pending = expected_positions.size();

   // register writes, responses then requests
   always @(posedge clock) begin
      position_type want, pos;
      if (reset) begin
         mount_x <= '0;
         mount_y <= '0;
         mount_z <= '0;
         expected_positions.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OFFSET_X: mount_x <= csr_data;
               CSR_OFFSET_Y: mount_y <= csr_data;
               CSR_OFFSET_Z: mount_z <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_positions.size() == 0) begin
               $display("%0t: response with no request outstanding", $realtime);
               fail_count++;
            end else begin
               want = expected_positions.pop_front();
               if (rsp_pos_x_mm !== want.x) report_mismatch("x", rsp_pos_x_mm, want.x);
               if (rsp_pos_y_mm !== want.y) report_mismatch("y", rsp_pos_y_mm, want.y);
               if (rsp_pos_z_mm !== want.z) report_mismatch("z", rsp_pos_z_mm, want.z);
            end
         end
         if (req_valid && req_ready) begin
            predict_position({req_distance_high, req_distance_low},
                             {req_azimuth_high, req_azimuth_low}, req_channel, pos);
            expected_positions.push_back(pos);
         end
      end
   end

   initial fail_count = 0;

endmodule

[test/lidar_return_to_cartesian_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_return_to_cartesian_test: stimulus and verdict for the converter
// Directed corner returns, then random returns under several mount offset
// settings, with bursty requests, a stalling receiver, one long hold-off
// and full drains, one of them mid-phase. Checking lives in the checker module.
// ----------------------------------------------------------------------------
module lidar_return_to_cartesian_test import lrc_pkg::*; ();

   localparam logic [1:0] CSR_NONE      = 2'd3;   // no register behind it
   localparam int         IDLE_LIMIT    = 5000;
   localparam int         PIPE_SETTLE   = 40;
   localparam int         LONG_HOLD     = 300;
   localparam int         RANDOM_PHASES = 5;
   localparam int         PHASE_ITEMS   = 120;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0, req_ready;
   logic [7:0]              req_distance_low = '0, req_distance_high = '0;
   logic [7:0]              req_azimuth_low = '0, req_azimuth_high = '0;
   logic [3:0]              req_channel = '0;
   logic                    rsp_valid, rsp_ready = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x_mm, rsp_pos_y_mm, rsp_pos_z_mm;
   logic                    csr_valid = 1'b0, csr_ready;
   logic [1:0]              csr_index = '0;
   logic [OFF_W-1:0]        csr_data = '0;
   int                      fail_count, positions_pending;
   bit                      long_hold_wanted = 1'b0;
   int                      idle_cycles = 0;

   lidar_return_to_cartesian dut (.*);
   lidar_return_to_cartesian_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: no progress on any channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: stall pattern changes every stretch, long hold-off on demand
   initial begin
      int mode;
      forever begin
         if (long_hold_wanted) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_wanted = 1'b0;
         end
         mode = $urandom_range(3);
         repeat ($urandom_range(16, 80)) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(1));
               2: rsp_ready <= ($urandom_range(3) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic push_return(input logic [15:0] count, input logic [15:0] az,
                              input logic [3:0] chan);
      req_valid         <= 1'b1;
      req_distance_low  <= count[7:0];
      req_distance_high <= count[15:8];
      req_azimuth_low   <= az[7:0];
      req_azimuth_high  <= az[15:8];
      req_channel       <= chan;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering and let every outstanding position come back
   task automatic drain_positions();
      req_valid <= 1'b0;
      @(posedge clock);
      while (positions_pending != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [OFF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_mounts(input int ox, input int oy, input int oz);
      write_register(CSR_OFFSET_X, OFF_W'(ox));
      write_register(CSR_OFFSET_Y, OFF_W'(oy));
      write_register(CSR_OFFSET_Z, OFF_W'(oz));
   endtask

   // random returns in bursts; azimuth mostly in range, some wrapping codes
   task automatic random_returns(input int count);
      int sent, burst;
      logic [15:0] az;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < count) begin
            az = $urandom_range(1) ? 16'($urandom_range(35999)) : 16'($urandom);
            push_return(16'($urandom), az, 4'($urandom));
            burst--;
            sent++;
         end
         if ($urandom_range(2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   initial begin
      logic [15:0] corner_az [12] = '{16'd0, 16'd4500, 16'd4501, 16'd8999, 16'd9000,
         16'd17999, 16'd18000, 16'd27000, 16'd35999, 16'd36000, 16'd40500, 16'hFFFF};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every channel, range extremes, quadrant and wrap corners
      for (int i = 0; i < 16; i++)
         push_return(i[0] ? 16'hFFFF : 16'h0001, corner_az[i % 12], 4'(i));
      for (int i = 0; i < 8; i++)
         push_return(i[0] ? 16'h0000 : 16'hFFFF, corner_az[(i * 5) % 12], 4'(15 - i));
      drain_positions();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: write_mounts(100000, -100000, 100000);
            1: write_mounts(-100000, 100000, -100000);
            2: write_mounts(131071, -131072, 0);
            3: write_mounts($urandom_range(200000) - 100000,
                            $urandom_range(200000) - 100000,
                            $urandom_range(200000) - 100000);
            default: begin
               write_mounts(0, 0, 0);
               write_register(CSR_NONE, OFF_W'($urandom));
            end
         endcase
         if (ph == 1) long_hold_wanted = 1'b1;
         random_returns(PHASE_ITEMS / 2);
         // full drain in mid-phase
         if (ph == 3) drain_positions();
         random_returns(PHASE_ITEMS / 2);
         drain_positions();
      end

      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/lrc_pkg.sv
rtl/lrc_front.sv
rtl/lrc_cell.sv
rtl/lrc_back.sv
rtl/lidar_return_to_cartesian.sv
test/lidar_return_to_cartesian_checker.sv
test/lidar_return_to_cartesian_test.sv
